// File: design/stalta_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// STA/LTA detector package
// Widths, register indexes and the divider request type shared by the
// detector top level and its ratio divider.
// ----------------------------------------------------------------------------
package stalta_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int SHORT_DEPTH = 256;
  localparam int LONG_DEPTH  = 4096;
  localparam int SHORT_AW    = $clog2(SHORT_DEPTH);
  localparam int LONG_AW     = $clog2(LONG_DEPTH);

  localparam int STA_W      = 9;
  localparam int LTA_W      = 13;
  localparam int SSUM_W     = 32;
  localparam int LSUM_W     = 36;
  localparam int PROD_W     = LSUM_W + LTA_W;
  localparam int NUM_W      = 45;
  localparam int FRAC_W     = 8;
  localparam int DVS_W      = NUM_W + FRAC_W;
  localparam int REM_W      = DVS_W + 1;
  localparam int RATIO_W    = 16;
  localparam int CNT_W      = $clog2(RATIO_W + 1);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [RATIO_W-1:0] Q8_ONE    = RATIO_W'(256);
  localparam logic [RATIO_W-1:0] RATIO_MAX = {RATIO_W{1'b1}};

  localparam logic [STA_W-1:0] STA_RESET = STA_W'(64);
  localparam logic [LTA_W-1:0] LTA_RESET = LTA_W'(1024);

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_STA_LEN = cfg_idx_t'(0);
  localparam cfg_idx_t REG_LTA_LEN = cfg_idx_t'(1);

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] den;
  } div_req_t;

endpackage

// File: design/stalta_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// STA/LTA ratio divider
// Restoring divider giving floor(num * 256 / den) saturated to 16 bits:
// an overflow check first, then one quotient bit per cycle.
// ----------------------------------------------------------------------------
module stalta_div (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  stalta_pkg::div_req_t                 req,
  output logic                                 done,
  output logic [stalta_pkg::RATIO_W-1:0]       quot
);
  import stalta_pkg::*;

  logic [REM_W-1:0]   rem_r;
  logic [DVS_W-1:0]   dvs_r;
  logic [RATIO_W-1:0] quot_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic               chk_r;
  logic               done_r;

  logic [REM_W-1:0]   trial;
  logic [REM_W-1:0]   diff;
  logic               ge;

  // The divisor carries the 8 fraction bits, so the remainder stays below it.
  always_comb begin
    trial = chk_r ? rem_r : {rem_r[REM_W-2:0], 1'b0};
    ge    = (trial >= {1'b0, dvs_r});
    diff  = trial - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      chk_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        chk_r  <= 1'b1;
      end else if (busy_r) begin
        if (chk_r) begin
          chk_r <= 1'b0;
          if (ge) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end else begin
            cnt_r <= CNT_W'(RATIO_W);
          end
        end else begin
          cnt_r <= cnt_r - CNT_W'(1);
          if (cnt_r == CNT_W'(1)) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= REM_W'(req.num);
      dvs_r  <= {req.den, {FRAC_W{1'b0}}};
      quot_r <= '0;
    end else if (busy_r) begin
      if (chk_r) begin
        if (ge) begin
          quot_r <= RATIO_MAX;
        end
      end else begin
        rem_r  <= ge ? diff : trial;
        quot_r <= {quot_r[RATIO_W-2:0], ge};
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

// File: design/sta_lta_event_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// STA/LTA event detector
// Short and long windows of sample magnitudes with running sums; each sample
// yields the Q8.8 ratio of the short average to the long average.
// ----------------------------------------------------------------------------
// Each accepted sample goes through the ring read (ST_RD), two multiplies (ST_MUL0,
// ST_MUL1), the 16-step restoring divider (ST_DIV), which stops after its overflow
// check when that saturates and is skipped while filling or with a zero long sum,
// then ST_OUT. A new sample is taken only back in ST_IDLE; a held output adds its wait.
// Reset (synchronous, rst_n low) and any length write empty both windows at
// once; ring entries not yet written since then read as zero via the fill count and full flag.
// ----------------------------------------------------------------------------
module sta_lta_event_detector (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: sample[23:0]
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [23:0]                       in_tdata,
  // out_tdata: ratio[15:0]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [15:0]                       out_tdata,
  // out_tuser: window_full[0], quiet_guard[1]
  output logic [1:0]                        out_tuser,
  input  logic                              cfg_we,
  input  stalta_pkg::cfg_idx_t              cfg_index,
  input  logic [stalta_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import stalta_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_MUL0 = 3'd2;
  localparam logic [2:0] ST_MUL1 = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]             state_r;
  logic [STA_W-1:0]       sta_len_r;
  logic [LTA_W-1:0]       lta_len_r;
  logic [SSUM_W-1:0]      short_sum_r;
  logic [LSUM_W-1:0]      long_sum_r;
  logic [SHORT_AW-1:0]    short_pos_r;
  logic [LONG_AW-1:0]     long_pos_r;
  logic [LTA_W-1:0]       fill_count_r;
  logic                   full_r;
  logic [SAMPLE_BITS-1:0] mag_r;
  logic [NUM_W-1:0]       num_r;
  logic [RATIO_W-1:0]     res_ratio_r;
  logic                   res_quiet_r;
  logic                   out_valid_r;
  logic [RATIO_W-1:0]     out_ratio_r;
  logic                   out_full_r;
  logic                   out_quiet_r;

  logic [SAMPLE_BITS-1:0] short_ring [SHORT_DEPTH];
  logic [SAMPLE_BITS-1:0] long_ring  [LONG_DEPTH];
  logic [SAMPLE_BITS-1:0] short_rd_r;
  logic [SAMPLE_BITS-1:0] long_rd_r;

  logic [LTA_W-1:0]       l_eff;
  logic [LTA_W-1:0]       s_cap;
  logic [LTA_W-1:0]       s_wide;
  logic [STA_W-1:0]       s_eff;
  logic                   in_fire;
  logic                   clr;
  logic                   out_load;
  logic [SAMPLE_BITS:0]   samp_ext;
  logic [SAMPLE_BITS:0]   samp_abs;
  logic [SAMPLE_BITS-1:0] short_old;
  logic [SAMPLE_BITS-1:0] long_old;
  logic [STA_W-1:0]       short_pos_inc;
  logic [LTA_W-1:0]       long_pos_inc;
  logic [LTA_W-1:0]       fill_inc;
  logic [LSUM_W-1:0]      mul_a;
  logic [LTA_W-1:0]       mul_b;
  logic [PROD_W-1:0]      prod;
  div_req_t               div_req;
  logic                   div_done;
  logic [RATIO_W-1:0]     div_quot;

  // Effective window lengths
  always_comb begin
    if (lta_len_r == '0) begin
      l_eff = LTA_W'(1);
    end else if (lta_len_r > LTA_W'(LONG_DEPTH)) begin
      l_eff = LTA_W'(LONG_DEPTH);
    end else begin
      l_eff = lta_len_r;
    end
    s_cap  = (l_eff < LTA_W'(SHORT_DEPTH)) ? l_eff : LTA_W'(SHORT_DEPTH);
    s_wide = LTA_W'(sta_len_r);
    if (s_wide == '0) begin
      s_wide = LTA_W'(1);
    end
    if (s_wide > s_cap) begin
      s_wide = s_cap;
    end
    s_eff = s_wide[STA_W-1:0];
  end

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign clr       = cfg_we && ((cfg_index == REG_STA_LEN) || (cfg_index == REG_LTA_LEN));
  assign out_load  = (state_r == ST_OUT) && (!out_valid_r || out_tready);

  // Magnitude; the most negative sample keeps its full value in SAMPLE_BITS bits.
  assign samp_ext = {in_tdata[SAMPLE_BITS-1], in_tdata};
  assign samp_abs = in_tdata[SAMPLE_BITS-1] ? ((SAMPLE_BITS + 1)'(0) - samp_ext) : samp_ext;

  // Slots not written since the last clear read as zero.
  assign short_old = (full_r || (fill_count_r >= LTA_W'(s_eff))) ? short_rd_r : '0;
  assign long_old  = full_r ? long_rd_r : '0;

  assign short_pos_inc = STA_W'(short_pos_r) + STA_W'(1);
  assign long_pos_inc  = LTA_W'(long_pos_r) + LTA_W'(1);
  assign fill_inc      = fill_count_r + LTA_W'(1);

  // Shared multiplier: short_sum*L, then long_sum*S
  always_comb begin
    if (state_r == ST_MUL0) begin
      mul_a = LSUM_W'(short_sum_r);
      mul_b = l_eff;
    end else begin
      mul_a = long_sum_r;
      mul_b = LTA_W'(s_eff);
    end
    prod = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  always_comb begin
    div_req.start = (state_r == ST_MUL1) && full_r && (long_sum_r != '0);
    div_req.num   = num_r;
    div_req.den   = prod[NUM_W-1:0];
  end

  stalta_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Rings: registered read at accept, write back in ST_RD in the cycle after.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      short_rd_r <= short_ring[short_pos_r];
      long_rd_r  <= long_ring[long_pos_r];
    end
    if (state_r == ST_RD) begin
      short_ring[short_pos_r] <= mag_r;
      long_ring[long_pos_r]   <= mag_r;
    end
  end

  // Control and window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      sta_len_r    <= STA_RESET;
      lta_len_r    <= LTA_RESET;
      short_sum_r  <= '0;
      long_sum_r   <= '0;
      short_pos_r  <= '0;
      long_pos_r   <= '0;
      fill_count_r <= '0;
      full_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (clr) begin
        short_sum_r  <= '0;
        long_sum_r   <= '0;
        short_pos_r  <= '0;
        long_pos_r   <= '0;
        fill_count_r <= '0;
        full_r       <= 1'b0;
        if (cfg_index == REG_STA_LEN) begin
          sta_len_r <= cfg_wdata[STA_W-1:0];
        end else begin
          lta_len_r <= cfg_wdata[LTA_W-1:0];
        end
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            state_r <= ST_RD;
          end
        end
        ST_RD: begin
          short_sum_r <= short_sum_r - SSUM_W'(short_old) + SSUM_W'(mag_r);
          long_sum_r  <= long_sum_r - LSUM_W'(long_old) + LSUM_W'(mag_r);
          short_pos_r <= (short_pos_inc >= s_eff) ? '0 : short_pos_inc[SHORT_AW-1:0];
          long_pos_r  <= (long_pos_inc >= l_eff) ? '0 : long_pos_inc[LONG_AW-1:0];
          if (!full_r) begin
            fill_count_r <= fill_inc;
            if (fill_inc >= l_eff) begin
              full_r <= 1'b1;
            end
          end
          state_r <= ST_MUL0;
        end
        ST_MUL0: begin
          state_r <= ST_MUL1;
        end
        ST_MUL1: begin
          state_r <= div_req.start ? ST_DIV : ST_OUT;
        end
        ST_DIV: begin
          if (div_done) begin
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mag_r <= samp_abs[SAMPLE_BITS-1:0];
    end
    if (state_r == ST_MUL0) begin
      num_r <= prod[NUM_W-1:0];
    end
    if (state_r == ST_MUL1) begin
      res_ratio_r <= Q8_ONE;
      res_quiet_r <= full_r && (long_sum_r == '0);
    end
    if ((state_r == ST_DIV) && div_done) begin
      res_ratio_r <= div_quot;
    end
    if (out_load) begin
      out_ratio_r <= res_ratio_r;
      out_full_r  <= full_r;
      out_quiet_r <= res_quiet_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_ratio_r;
  assign out_tuser  = {out_quiet_r, out_full_r};

endmodule

// File: tb/sta_lta_ratio_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// STA/LTA ratio checker
// Watches the sample, ratio and register ports of the detector and keeps its
// own copy of both magnitude windows. Each accepted sample beat queues the
// expected ratio beat. Each accepted ratio beat is checked field by field
// against the oldest entry in that queue.
// ----------------------------------------------------------------------------
module sta_lta_ratio_checker (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  input  logic                                  in_tready,
  input  logic [stalta_pkg::SAMPLE_BITS-1:0]    in_tdata,
  input  logic                                  out_tvalid,
  input  logic                                  out_tready,
  input  logic [stalta_pkg::RATIO_W-1:0]        out_tdata,
  input  logic [1:0]                            out_tuser,
  input  logic                                  cfg_we,
  input  stalta_pkg::cfg_idx_t                  cfg_index,
  input  logic [stalta_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output int                                    pending,
  output int                                    fail_count
);
  import stalta_pkg::*;

  typedef struct packed {
    logic [RATIO_W-1:0] ratio;
    logic               full;
    logic               quiet;
  } ratio_beat_t;

  logic [SAMPLE_BITS-1:0] short_mag [SHORT_DEPTH];
  logic [SAMPLE_BITS-1:0] long_mag  [LONG_DEPTH];
  longint unsigned        short_total;
  longint unsigned        long_total;
  int unsigned            short_wr;
  int unsigned            long_wr;
  int unsigned            seen;
  logic                   window_done;
  logic [STA_W-1:0]       sta_reg;
  logic [LTA_W-1:0]       lta_reg;
  ratio_beat_t            ratio_q [$];

  initial begin
    pending    = 0;
    fail_count = 0;
  end

  task automatic report(input string field, input longint unsigned got,
                        input longint unsigned want);
    $display("mismatch at %0t ns: %s got %0d expected %0d", $time, field, got, want);
    fail_count++;
  endtask

  task automatic clear_windows();
    for (int i = 0; i < SHORT_DEPTH; i++) short_mag[i] = '0;
    for (int i = 0; i < LONG_DEPTH; i++) long_mag[i] = '0;
    short_total = 0;
    long_total  = 0;
    short_wr    = 0;
    long_wr     = 0;
    seen        = 0;
    window_done = 1'b0;
  endtask

  // Advance both windows by one sample and return the ratio beat it causes.
  function automatic ratio_beat_t predict_ratio(input logic [SAMPLE_BITS-1:0] smp);
    int unsigned            long_span;
    int unsigned            short_span;
    int unsigned            cap;
    logic [SAMPLE_BITS-1:0] mag;
    longint unsigned        num;
    longint unsigned        den;
    longint unsigned        quo;
    ratio_beat_t            beat;

    long_span  = (lta_reg == 0) ? 1 : ((lta_reg > LONG_DEPTH) ? LONG_DEPTH : lta_reg);
    cap        = (long_span < SHORT_DEPTH) ? long_span : SHORT_DEPTH;
    short_span = (sta_reg == 0) ? 1 : ((sta_reg > cap) ? cap : sta_reg);
    // most negative sample wraps onto itself, which is its exact magnitude
    mag = smp[SAMPLE_BITS-1] ? (~smp + 1'b1) : smp;

    if (short_wr >= short_span) short_wr = 0;
    if (long_wr >= long_span) long_wr = 0;

    short_total         = short_total - short_mag[short_wr] + mag;
    short_mag[short_wr] = mag;
    short_wr            = (short_wr + 1 >= short_span) ? 0 : short_wr + 1;

    long_total        = long_total - long_mag[long_wr] + mag;
    long_mag[long_wr] = mag;
    long_wr           = (long_wr + 1 >= long_span) ? 0 : long_wr + 1;

    if (!window_done) begin
      seen++;
      if (seen >= long_span) window_done = 1'b1;
    end

    beat.ratio = Q8_ONE;
    beat.full  = window_done;
    beat.quiet = 1'b0;
    if (window_done) begin
      if (long_total == 0) begin
        beat.quiet = 1'b1;
      end else begin
        num = short_total * long_span * 64'd256;
        den = long_total * short_span;
        quo = num / den;
        beat.ratio = (quo > RATIO_MAX) ? RATIO_MAX : quo[RATIO_W-1:0];
      end
    end
    return beat;
  endfunction

  always @(posedge clk) begin : watch
    ratio_beat_t got;
    ratio_beat_t want;
    if (!rst_n) begin
      sta_reg = STA_RESET;
      lta_reg = LTA_RESET;
      clear_windows();
      ratio_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_STA_LEN) begin
          sta_reg = cfg_wdata[STA_W-1:0];
          clear_windows();
        end else if (cfg_index == REG_LTA_LEN) begin
          lta_reg = cfg_wdata[LTA_W-1:0];
          clear_windows();
        end
      end
      if (in_tvalid && in_tready) ratio_q.push_back(predict_ratio(in_tdata));
      if (out_tvalid && out_tready) begin
        got.ratio = out_tdata;
        got.full  = out_tuser[0];
        got.quiet = out_tuser[1];
        if (ratio_q.size() == 0) begin
          report("ratio beat with nothing pending, ratio", got.ratio, 0);
        end else begin
          want = ratio_q.pop_front();
          if (got.ratio !== want.ratio) report("ratio", got.ratio, want.ratio);
          if (got.full !== want.full) report("window_full", got.full, want.full);
          if (got.quiet !== want.quiet) report("quiet_guard", got.quiet, want.quiet);
        end
      end
    end
    pending = ratio_q.size();
  end

endmodule

// File: tb/sta_lta_event_detector_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// STA/LTA event detector testbench
// Drives seismic-like sample streams through the detector across many window
// length settings. It mixes quiet stretches, low noise and loud bursts, and
// uses random stalls on both streams. A separate checker predicts and
// compares every ratio beat. This module makes the stimulus and gives the
// verdict.
// ----------------------------------------------------------------------------
module sta_lta_event_detector_tb;
  import stalta_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 7;
  localparam int RANDOM_ITEMS = 1850;
  localparam int DRAIN_CYCLES = 40;
  localparam int LIMIT_CYCLES = 800000;

  // indexes with no register behind them
  localparam cfg_idx_t REG_SPARE_A = cfg_idx_t'(2);
  localparam cfg_idx_t REG_SPARE_B = cfg_idx_t'(3);

  typedef enum int {LVL_ZERO, LVL_TINY, LVL_MODERATE, LVL_FULL, LVL_EXTREME} amp_level_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [SAMPLE_BITS-1:0] in_tdata;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [RATIO_W-1:0]     out_tdata;
  logic [1:0]             out_tuser;
  logic                   cfg_we;
  cfg_idx_t               cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;
  int                     pending;
  int                     fail_count;
  int                     cycle_count   = 0;
  int                     send_idle_pct = 36;
  int                     recv_idle_pct = 46;
  int                     samples_sent  = 0;
  int                     cur_lta       = LTA_RESET;

  sta_lta_event_detector u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  sta_lta_ratio_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .pending   (pending),
    .fail_count(fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == REG_LTA_LEN) cur_lta = val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Hold valid low until every expected ratio beat is back.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic push_sample(input logic [SAMPLE_BITS-1:0] smp);
    if ($urandom_range(0, 149) == 0) begin
      drain();
    end else if ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 30) : $urandom_range(1, 3))
        @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= smp;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    samples_sent++;
  endtask

  function automatic amp_level_t pick_level(input bit burst_phase);
    int r;
    r = $urandom_range(0, 99);
    if (burst_phase)
      return (r < 45) ? LVL_ZERO : (r < 85) ? LVL_TINY : (r < 95) ? LVL_FULL : LVL_EXTREME;
    return (r < 20) ? LVL_ZERO : (r < 40) ? LVL_TINY : (r < 60) ? LVL_MODERATE :
           (r < 85) ? LVL_FULL : LVL_EXTREME;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] draw_sample(input amp_level_t level);
    int          v;
    int          pick;
    bit [31:0]   r;
    r    = $urandom();
    pick = $urandom_range(0, 5);
    case (level)
      LVL_ZERO:     v = 0;
      LVL_TINY:     v = int'($urandom_range(0, 6)) - 3;
      LVL_MODERATE: v = int'($urandom_range(0, 8191)) - 4096;
      LVL_FULL:     v = int'(r);
      default: begin
        case (pick)
          0:       v = 'h7fffff;
          1:       v = 'h800000;
          2:       v = 'h800001;
          3:       v = 'hffffff;
          4:       v = 1;
          default: v = 0;
        endcase
      end
    endcase
    return v[SAMPLE_BITS-1:0];
  endfunction

  // One settings phase: new window lengths, then a stream of segments.
  task automatic run_phase();
    int                    kind;
    int                    lta;
    int                    sta;
    int                    which;
    int                    span;
    int                    count;
    int                    seg_left;
    amp_level_t            level;
    logic [CFG_DATA_W-1:0] sta_word;

    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      // long window against a one-to-three sample short window: bursts saturate
      lta = $urandom_range(257, 360);
      sta = $urandom_range(1, 3);
    end else if (kind == 1) begin
      case ($urandom_range(0, 4))
        0:       lta = 1;
        1:       lta = 2;
        2:       lta = 255;
        3:       lta = 256;
        default: lta = 257;
      endcase
      case ($urandom_range(0, 5))
        0:       sta = 0;
        1:       sta = 1;
        2:       sta = 255;
        3:       sta = 256;
        4:       sta = 257;
        default: sta = 511;
      endcase
    end else begin
      lta = $urandom_range(1, 48);
      sta = $urandom_range(0, lta + 3);
    end

    if (samples_sent < RANDOM_ITEMS / 3) begin
      send_idle_pct = 36;
      recv_idle_pct = 46;
    end else if (samples_sent < 2 * RANDOM_ITEMS / 3) begin
      send_idle_pct = 46;
      recv_idle_pct = 36;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end

    sta_word                       = CFG_DATA_W'(sta);
    sta_word[CFG_DATA_W-1:STA_W]   = (CFG_DATA_W - STA_W)'($urandom());
    which = $urandom_range(0, 3);
    if (cur_lta > 400) which = 2;

    drain();
    case (which)
      0:       write_reg(REG_STA_LEN, sta_word);
      1:       write_reg(REG_LTA_LEN, CFG_DATA_W'(lta));
      default: begin
        if ($urandom_range(0, 1)) begin
          write_reg(REG_STA_LEN, sta_word);
          write_reg(REG_LTA_LEN, CFG_DATA_W'(lta));
        end else begin
          write_reg(REG_LTA_LEN, CFG_DATA_W'(lta));
          write_reg(REG_STA_LEN, sta_word);
        end
      end
    endcase

    span     = (cur_lta == 0) ? 1 : ((cur_lta > LONG_DEPTH) ? LONG_DEPTH : cur_lta);
    count    = span + $urandom_range(10, 80);
    seg_left = 0;
    level    = LVL_ZERO;
    repeat (count) begin
      if (seg_left == 0) begin
        level    = pick_level(kind == 0);
        seg_left = (kind == 0 && level >= LVL_FULL) ? $urandom_range(1, 6)
                                                     : $urandom_range(1, 40);
      end
      push_sample(draw_sample(level));
      seg_left--;
    end
  endtask

  initial begin
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_STA_LEN;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset lengths: window still filling, ratio pinned at one
    push_sample(24'h7fffff);
    push_sample(24'h800000);
    push_sample(24'h000000);
    push_sample(24'hffffff);
    push_sample(24'h000001);

    // writes to unused indexes must not clear the windows
    drain();
    write_reg(REG_SPARE_A, '1);
    write_reg(REG_SPARE_B, '0);
    push_sample(24'h7fffff);

    // zero lengths clip to one: full after a single sample
    drain();
    write_reg(REG_STA_LEN, '0);
    write_reg(REG_LTA_LEN, '0);
    push_sample(24'h000000);
    push_sample(24'h800000);
    push_sample(24'h000005);

    // quiet window, then a loud sample against a short window of two
    drain();
    write_reg(REG_LTA_LEN, CFG_DATA_W'(4));
    write_reg(REG_STA_LEN, CFG_DATA_W'(2));
    repeat (4) push_sample(24'h000000);
    push_sample(24'h800000);
    push_sample(24'h7fffff);

    // short length above the long one clips to it
    drain();
    write_reg(REG_STA_LEN, '1);
    push_sample(24'h123456);
    push_sample(24'hedcba9);
    push_sample(24'h000000);
    push_sample(24'h800001);

    // long length past the ring depth clips to the ring depth
    drain();
    write_reg(REG_LTA_LEN, '1);
    push_sample(24'h555555);
    push_sample(24'haaaaaa);

    samples_sent = 0;
    while (samples_sent < RANDOM_ITEMS) run_phase();

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sta_lta_event_detector.f
design/stalta_pkg.sv
design/stalta_div.sv
design/sta_lta_event_detector.sv
tb/sta_lta_ratio_checker.sv
tb/sta_lta_event_detector_tb.sv
